// ===== rtl/v3n_pkg.sv =====
`default_nettype none

package v3n_pkg;

  localparam int CompW    = 16;  // input and output component width
  localparam int SqW      = 31;  // square of a 16-bit magnitude (max 2^30)
  localparam int DenW     = 32;  // sum of three squares
  localparam int QuoW     = 30;  // quotient, padded to an even width for the root
  localparam int DivSteps = 29;  // quotient bits
  localparam int URootW   = 15;  // root of the quotient
  localparam int URemW    = URootW + 2;
  localparam int MRootW   = 16;  // root of the sum of squares
  localparam int MRemW    = MRootW + 2;

  // stage map
  localparam int StAbs     = 0;
  localparam int StSq      = 1;
  localparam int StSum     = 2;
  localparam int StDiv0    = 3;
  localparam int StMag0    = StDiv0;
  localparam int MagSteps  = MRootW;
  localparam int StUsq0    = StDiv0 + DivSteps;
  localparam int USqSteps  = URootW;
  localparam int StOut     = StUsq0 + USqSteps;
  localparam int NumStages = StOut + 1;

  typedef struct packed {
    logic [2:0]              sgn;
    logic                    zero;
    logic [2:0][SqW-1:0]     sq;
    logic [DenW-1:0]         den;
    logic [2:0][DenW-1:0]    rem;
    logic [2:0][QuoW-1:0]    quo;
    logic [2:0][URemW-1:0]   urem;
    logic [2:0][URootW-1:0]  uroot;
    logic [DenW-1:0]         mrad;
    logic [MRemW-1:0]        mrem;
    logic [MRootW-1:0]       mroot;
    logic [2:0][CompW-1:0]   unit;
  } pipe_t;

endpackage

`default_nettype wire

// ===== rtl/v3n_div_step.sv =====
`default_nettype none

module v3n_div_step
  import v3n_pkg::*;
(
  input  logic [DenW-1:0] rem_i,
  input  logic [DenW-1:0] den_i,
  input  logic            bit_i,
  output logic [DenW-1:0] rem_o,
  output logic            q_o
);

  logic [DenW:0] trial;
  logic [DenW:0] diff;

  // one restoring step: shift in a numerator bit, subtract if it fits
  always_comb begin
    trial = {rem_i, bit_i};
    diff  = trial - {1'b0, den_i};
    q_o   = (trial >= {1'b0, den_i});
    rem_o = q_o ? diff[DenW-1:0] : trial[DenW-1:0];
  end

endmodule

`default_nettype wire

// ===== rtl/v3n_sqrt_step.sv =====
`default_nettype none

module v3n_sqrt_step #(
  parameter int RootW = 16
) (
  input  logic [RootW+1:0] rem_i,
  input  logic [RootW-1:0] root_i,
  input  logic [1:0]       bits_i,
  output logic [RootW+1:0] rem_o,
  output logic [RootW-1:0] root_o
);

  localparam int RemW = RootW + 2;

  logic [RemW+1:0] trial;
  logic [RemW+1:0] tst;
  logic [RemW+1:0] diff;
  logic            ge;

  // one root bit: bring down two radicand bits, try 4*root+1
  always_comb begin
    trial  = {rem_i, bits_i};
    tst    = (RemW+2)'({root_i, 2'b01});
    diff   = trial - tst;
    ge     = (trial >= tst);
    rem_o  = ge ? diff[RemW-1:0] : trial[RemW-1:0];
    root_o = {root_i[RootW-2:0], ge};
  end

endmodule

`default_nettype wire

// ===== rtl/vector3_normalize.sv =====
`default_nettype none

// vector3_normalize: length and unit vector of a 3D vector
// input channel: in_valid_i / in_ready_o carry one word of three signed
//   q8.8 components (vec_x_i, vec_y_i, vec_z_i)
// output channel: out_valid_o / out_ready_i carry one word per input word:
//   unit_x_o..unit_z_o signed q1.14 truncated toward zero, magnitude_o
//   unsigned q8.8 truncated, zero_vector_o set for an all-zero input
// a zero input gives zero unit components and zero magnitude
// throughput: one word per cycle while the output is not stalled, no state between words
// depth: 48 register stages; the 29 one-bit divide steps and the 15
//   one-bit root steps that follow them, with the abs, square, sum and
//   output stages, make up that depth
// each stage holds its own valid bit and loads whenever it is empty or its
//   successor moves, so bubbles close up under a stall
// a stalled receiver holds the output word; input is refused only when
//   every stage holds a word
// reset clears all valid bits; the pipeline is empty and ready after reset

module vector3_normalize
  import v3n_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [CompW-1:0] vec_x_i,
  input  logic signed [CompW-1:0] vec_y_i,
  input  logic signed [CompW-1:0] vec_z_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [CompW-1:0] unit_x_o,
  output logic signed [CompW-1:0] unit_y_o,
  output logic signed [CompW-1:0] unit_z_o,
  output logic [CompW-1:0]        magnitude_o,
  output logic                    zero_vector_o
);

  pipe_t                p_q [NumStages];
  pipe_t                p_d [NumStages];
  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] v_d;
  logic [NumStages:0]   adv;   // stage loads when set

  logic signed [CompW-1:0] vec_in [3];
  assign vec_in[0] = vec_x_i;
  assign vec_in[1] = vec_y_i;
  assign vec_in[2] = vec_z_i;

  // load chain: a stage takes a word if it is empty or its word moves on
  assign adv[NumStages] = out_ready_i;
  genvar s, c;
  for (s = 0; s < NumStages; s++) begin : g_adv
    assign adv[s] = ~v_q[s] | adv[s+1];
    if (s == 0) begin : g_v0
      assign v_d[s] = adv[s] ? in_valid_i : v_q[s];
    end else begin : g_vn
      assign v_d[s] = adv[s] ? v_q[s-1] : v_q[s];
    end
  end
  assign in_ready_o = adv[0];

  for (s = 0; s < NumStages; s++) begin : g_st
    if (s == StAbs) begin : g_abs
      // sign and absolute value of each component
      always_comb begin
        p_d[s] = '0;
        for (int i = 0; i < 3; i++) begin
          p_d[s].sgn[i] = vec_in[i][CompW-1];
          p_d[s].sq[i]  = SqW'(vec_in[i][CompW-1] ? (CompW'(0) - vec_in[i])
                                                  : vec_in[i]);
        end
        p_d[s].zero = (vec_x_i == '0) && (vec_y_i == '0) && (vec_z_i == '0);
      end
    end else if (s == StSq) begin : g_sq
      logic [2:0][2*CompW-1:0] prod;
      always_comb begin
        p_d[s] = p_q[s-1];
        for (int i = 0; i < 3; i++) begin
          prod[i]      = p_q[s-1].sq[i][CompW-1:0] * p_q[s-1].sq[i][CompW-1:0];
          p_d[s].sq[i] = prod[i][SqW-1:0];
        end
      end
    end else if (s == StSum) begin : g_sum
      always_comb begin
        p_d[s]       = p_q[s-1];
        p_d[s].den   = DenW'(p_q[s-1].sq[0]) + DenW'(p_q[s-1].sq[1])
                     + DenW'(p_q[s-1].sq[2]);
        p_d[s].mrad  = p_d[s].den;
        p_d[s].mrem  = '0;
        p_d[s].mroot = '0;
        for (int i = 0; i < 3; i++) begin
          // numerator is sq << 28; its top part sq >> 1 is below den for a nonzero vector
          p_d[s].rem[i]   = DenW'(p_q[s-1].sq[i][SqW-1:1]);
          p_d[s].quo[i]   = '0;
          p_d[s].urem[i]  = '0;
          p_d[s].uroot[i] = '0;
        end
      end
    end else if (s < StUsq0) begin : g_div
      logic [2:0][DenW-1:0] rem_n;
      logic [2:0]           qb;
      logic [MRemW-1:0]     mrem_n;
      logic [MRootW-1:0]    mroot_n;
      for (c = 0; c < 3; c++) begin : g_c
        v3n_div_step u_div (
          .rem_i (p_q[s-1].rem[c]),
          .den_i (p_q[s-1].den),
          .bit_i ((s == StDiv0) ? p_q[s-1].sq[c][0] : 1'b0),
          .rem_o (rem_n[c]),
          .q_o   (qb[c])
        );
      end
      if (s < StMag0 + MagSteps) begin : g_mag
        v3n_sqrt_step #(.RootW(MRootW)) u_msq (
          .rem_i  (p_q[s-1].mrem),
          .root_i (p_q[s-1].mroot),
          .bits_i (p_q[s-1].mrad[DenW-1:DenW-2]),
          .rem_o  (mrem_n),
          .root_o (mroot_n)
        );
      end else begin : g_mhold
        assign mrem_n  = p_q[s-1].mrem;
        assign mroot_n = p_q[s-1].mroot;
      end
      always_comb begin
        p_d[s]       = p_q[s-1];
        p_d[s].mrem  = mrem_n;
        p_d[s].mroot = mroot_n;
        p_d[s].mrad  = {p_q[s-1].mrad[DenW-3:0], 2'b00};
        for (int i = 0; i < 3; i++) begin
          p_d[s].rem[i] = rem_n[i];
          p_d[s].quo[i] = {p_q[s-1].quo[i][QuoW-2:0], qb[i]};
        end
      end
    end else if (s < StOut) begin : g_usq
      logic [2:0][URemW-1:0]  urem_n;
      logic [2:0][URootW-1:0] uroot_n;
      for (c = 0; c < 3; c++) begin : g_c
        v3n_sqrt_step #(.RootW(URootW)) u_usq (
          .rem_i  (p_q[s-1].urem[c]),
          .root_i (p_q[s-1].uroot[c]),
          .bits_i (p_q[s-1].quo[c][QuoW-1:QuoW-2]),
          .rem_o  (urem_n[c]),
          .root_o (uroot_n[c])
        );
      end
      always_comb begin
        p_d[s] = p_q[s-1];
        for (int i = 0; i < 3; i++) begin
          p_d[s].urem[i]  = urem_n[i];
          p_d[s].uroot[i] = uroot_n[i];
          p_d[s].quo[i]   = {p_q[s-1].quo[i][QuoW-3:0], 2'b00};
        end
      end
    end else begin : g_out
      // restore signs; a zero vector forces the unit components and magnitude to zero
      logic [2:0][CompW-1:0] mag16;
      always_comb begin
        p_d[s] = p_q[s-1];
        for (int i = 0; i < 3; i++) begin
          mag16[i]       = CompW'(p_q[s-1].uroot[i]);
          p_d[s].unit[i] = p_q[s-1].sgn[i] ? (CompW'(0) - mag16[i]) : mag16[i];
          if (p_q[s-1].zero) begin
            p_d[s].unit[i] = '0;
          end
        end
        if (p_q[s-1].zero) begin
          p_d[s].mroot = '0;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[s]) begin
        p_q[s] <= p_d[s];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign out_valid_o   = v_q[StOut];
  assign unit_x_o      = p_q[StOut].unit[0];
  assign unit_y_o      = p_q[StOut].unit[1];
  assign unit_z_o      = p_q[StOut].unit[2];
  assign magnitude_o   = p_q[StOut].mroot;
  assign zero_vector_o = p_q[StOut].zero;

`ifndef SYNTHESIS
  a_full_only_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input refused while output is not stalled");

  a_zero_outputs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && zero_vector_o) |-> (magnitude_o == '0 && unit_x_o == '0
      && unit_y_o == '0 && unit_z_o == '0))
    else $error("zero vector with nonzero outputs");

  a_nonzero_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !zero_vector_o) |-> (magnitude_o != '0))
    else $error("nonzero vector with zero magnitude");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (unit_x_o >= -16'sd16384 && unit_x_o <= 16'sd16384
      && unit_y_o >= -16'sd16384 && unit_y_o <= 16'sd16384
      && unit_z_o >= -16'sd16384 && unit_z_o <= 16'sd16384))
    else $error("unit component out of range");
`endif

endmodule

`default_nettype wire
